// File: hdl/assert_macros.svh
// Assertion macros for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is high.
`define BSDE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define BSDE_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: hdl/bsde_pkg.sv
// Types and constants for the bit subset deposit/extract block.
package bsde_pkg;

   // Fixed field widths
   localparam int DATA_WIDTH      = 32;
   localparam int IDX_WIDTH       = $clog2(DATA_WIDTH);
   localparam int COUNT_WIDTH     = IDX_WIDTH + 1;
   localparam int AW_WIDTH        = 6;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int WIDTH_DEFAULT   = 32;

   // Configuration reset values
   localparam logic [DATA_WIDTH-1:0] USED_MASK_RESET    = '1;
   localparam logic [AW_WIDTH-1:0]   ACTIVE_WIDTH_RESET = AW_WIDTH'(32);

   // Operation codes
   typedef enum logic {
      FUNC_DEPOSIT = 1'b0,
      FUNC_EXTRACT = 1'b1
   } func_type;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_USED_MASK    = CSR_INDEX_WIDTH'(0),
      CSR_ACTIVE_WIDTH = CSR_INDEX_WIDTH'(1)
   } csr_index_type;

   // Work carried by an item as it walks the cell chain
   typedef struct packed {
      func_type                func;
      logic [DATA_WIDTH-1:0]   operand;
      logic [DATA_WIDTH-1:0]   result;
      logic [COUNT_WIDTH-1:0]  count;
   } payload_type;

   // Link between neighboring cells
   typedef struct packed {
      logic        valid;
      payload_type data;
   } link_type;

endpackage

// File: hdl/bsde_channels.sv
// Handshake channel interfaces: request, response and configuration write.

interface bsde_req_if
   import bsde_pkg::*;
();
   logic                  valid;
   logic                  ready;
   func_type              func;
   logic [DATA_WIDTH-1:0] operand_value;

   modport source (output valid, output func, output operand_value, input ready);
   modport sink   (input valid, input func, input operand_value, output ready);
endinterface

interface bsde_rsp_if
   import bsde_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] result_value;

   modport source (output valid, output result_value, input ready);
   modport sink   (input valid, input result_value, output ready);
endinterface

interface bsde_csr_if
   import bsde_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [DATA_WIDTH-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/bit_subset_deposit_extract.sv
// Top level: bit subset deposit/extract over a chain of bit-position cells.
//
//   channel  dir  fields                      accepted when
//   req_ch   in   func, operand_value         valid && ready
//   rsp_ch   out  result_value                valid && ready
//   csr_ch   in   index, data                 valid && ready (ready tied high)
//
// One item enters per cycle unless the chain is stalled; each passes through
// the bit-position cells in order, one register per cell, then the output register.
// Each cell holds its own valid bit, so bubbles close up under a stall and
// items are still taken while a result waits in the output register, until the chain fills.
// Reset clears all valid bits and loads used_mask to all ones, active_width to 32.
module bit_subset_deposit_extract
   import bsde_pkg::*;
#(
   parameter int WIDTH = WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   bsde_req_if.sink   req_ch,
   bsde_rsp_if.source rsp_ch,
   bsde_csr_if.sink   csr_ch
);

   localparam int CELLS = (WIDTH < DATA_WIDTH) ? WIDTH : DATA_WIDTH;

   logic [CELLS-1:0] eff_mask;
   link_type         links [0:CELLS];
   logic [CELLS:0]   adv;

   // Configuration
   bsde_csr #(.CELLS(CELLS)) u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr_ch),
      .eff_mask (eff_mask)
   );

   // Entry into the chain
   assign links[0].valid        = req_ch.valid;
   assign links[0].data.func    = req_ch.func;
   assign links[0].data.operand = req_ch.operand_value;
   assign links[0].data.result  = '0;
   assign links[0].data.count   = '0;
   assign req_ch.ready          = adv[0];

   // One cell per bit position, lowest first
   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      bsde_cell #(.POS(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .prev_link (links[i]),
         .mask_bit  (eff_mask[i]),
         .adv_out   (adv[i+1]),
         .adv_in    (adv[i]),
         .next_link (links[i+1])
      );
   end

   // Result register
   bsde_out u_out (
      .clock     (clock),
      .reset     (reset),
      .last_link (links[CELLS]),
      .adv_in    (adv[CELLS]),
      .rsp       (rsp_ch)
   );

endmodule

// File: hdl/bsde_csr.sv
// Configuration registers and the effective position mask.
module bsde_csr
   import bsde_pkg::*;
#(
   parameter int CELLS = WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   bsde_csr_if.sink         csr,
   output logic [CELLS-1:0] eff_mask
);

   logic [DATA_WIDTH-1:0] used_mask_ff;
   logic [AW_WIDTH-1:0]   active_width_ff;

   // Writes are always taken
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_mask_ff    <= USED_MASK_RESET;
         active_width_ff <= ACTIVE_WIDTH_RESET;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_USED_MASK:    used_mask_ff    <= csr.data;
            CSR_ACTIVE_WIDTH: active_width_ff <= csr.data[AW_WIDTH-1:0];
            default: ;  // unknown index: write dropped
         endcase
      end
   end

   // A position counts if it is used and below the active width
   always_comb begin
      for (int i = 0; i < CELLS; i++) begin
         eff_mask[i] = used_mask_ff[i] && (AW_WIDTH'(i) < active_width_ff);
      end
   end

endmodule

// File: hdl/bsde_cell.sv
// One bit-position cell of the deposit/extract chain.
module bsde_cell
   import bsde_pkg::*;
#(
   parameter int POS = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  link_type prev_link,
   input  logic     mask_bit,
   input  logic     adv_out,
   output logic     adv_in,
   output link_type next_link
);

   logic        valid_ff;
   payload_type payload_ff;
   payload_type payload_in;

   // Register loads when empty or when its item moves on
   assign adv_in = !valid_ff || adv_out;

   // Handle this position when the mask uses it
   always_comb begin
      payload_in = prev_link.data;
      if (mask_bit) begin
         case (prev_link.data.func)
            FUNC_DEPOSIT: begin
               // next index bit lands here; index shifts down
               payload_in.result[POS] = prev_link.data.operand[0];
               payload_in.operand     = prev_link.data.operand >> 1;
            end
            FUNC_EXTRACT: begin
               // this value bit goes to the next packed slot
               payload_in.result[prev_link.data.count[IDX_WIDTH-1:0]] =
                  prev_link.data.operand[POS];
               payload_in.count = prev_link.data.count + 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv_in) begin
         valid_ff <= prev_link.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_in) begin
         payload_ff <= payload_in;
      end
   end

   assign next_link.valid = valid_ff;
   assign next_link.data  = payload_ff;

endmodule

// File: hdl/bsde_out.sv
// Output register that drives the response channel.
module bsde_out
   import bsde_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  link_type  last_link,
   output logic      adv_in,
   bsde_rsp_if.source rsp
);

   logic                  valid_ff;
   logic [DATA_WIDTH-1:0] result_ff;

   // Free slot or item leaving this cycle
   assign adv_in = !valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv_in) begin
         valid_ff <= last_link.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_in) begin
         result_ff <= last_link.data.result;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.result_value = result_ff;

endmodule

// File: hdl/bsde_checker.sv
// Port-level assertions for the deposit/extract block and their bind.
`include "assert_macros.svh"

module bsde_checker
   import bsde_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [DATA_WIDTH-1:0] rsp_result,
   input logic                  csr_ready
);

   // A stalled result stays and keeps its value
   `BSDE_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_result)), "stalled result changed")

   // Reset empties the output register
   `BSDE_ASSERT_RST(a_reset_empty, reset |=> !rsp_valid, "result valid after reset")

   // A free or draining output register never blocks the request side
   `BSDE_ASSERT(a_req_open, (!rsp_valid || rsp_ready) |-> req_ready, "request blocked with free output")

   // Configuration writes are never back-pressured
   `BSDE_ASSERT(a_csr_ready, csr_ready, "configuration port not ready")

   // No result right after reset if no request was valid while reset was high
   `BSDE_ASSERT(a_no_phantom, ($past(reset) && !$past(req_valid)) |-> !rsp_valid, "result without request")

endmodule

bind bit_subset_deposit_extract bsde_checker u_bsde_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_result (rsp_ch.result_value),
   .csr_ready  (csr_ch.ready)
);
